>>> hdl/rtat_pkg.sv
// Shared widths, codes and types for the rank-to-address translator.
`default_nettype none

package rtat_pkg;

   // default sizes of the tables
   localparam int NUM_BANKS_DEF  = 4;
   localparam int ADDR_DEPTH_DEF = 1024;
   localparam int RANK_DEPTH_DEF = 1024;

   // field widths
   localparam int REQ_W      = 2;
   localparam int RANK_W     = 10;
   localparam int BANK_W     = 2;
   localparam int SLOT_W     = 10;
   localparam int ENTRY_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int MODE_W     = 4;
   localparam int MAP_W      = BANK_W + SLOT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // datapath widths
   localparam int MULB_W    = RANK_W + 1;
   localparam int PROD_W    = 2 * MULB_W;
   localparam int ADDEND_W  = RANK_W + 1;
   localparam int CALC_W    = 24;
   localparam int DIV_CNT_W = 4;
   localparam int STATE_W   = 4;

   // request types
   localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WR_ADDR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_WR_MAP  = 2'd2;

   // mapping modes
   localparam logic [MODE_W-1:0] MODE_DIRECT       = 4'd0;
   localparam logic [MODE_W-1:0] MODE_DIRECT_INTRA = 4'd1;
   localparam logic [MODE_W-1:0] MODE_OFFSET       = 4'd2;
   localparam logic [MODE_W-1:0] MODE_OFFSET_INTRA = 4'd3;
   localparam logic [MODE_W-1:0] MODE_STRIDE       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_STRIDE_INTRA = 4'd5;
   localparam logic [MODE_W-1:0] MODE_BLOCK        = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BLOCK_INTRA  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_LUT          = 4'd8;
   localparam logic [MODE_W-1:0] MODE_LUT_INTRA    = 4'd9;
   localparam logic [MODE_W-1:0] MODE_MULTI_LUT    = 4'd10;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BLOCK = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MODE  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK  = 3'd4;

   // table strobes from the sequencer
   typedef struct packed {
      logic at_we;
      logic at_re;
      logic rm_we;
      logic rm_re;
   } tbl_ctl_type;

endpackage

`default_nettype wire

>>> hdl/rtat_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rtat_div
   import rtat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [RANK_W-1:0] dividend,
   input  wire logic [RANK_W-1:0] divisor,
   output logic                   done,
   output logic [RANK_W-1:0]      quotient
);

   logic [RANK_W:0]      rem_ff, rem_in;
   logic [RANK_W-1:0]    quo_ff, quo_in;
   logic [RANK_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RANK_W:0]      shifted;
   logic [RANK_W+1:0]    diff;

   assign shifted = {rem_ff[RANK_W-1:0], quo_ff[RANK_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the difference unless it borrowed
         if (!diff[RANK_W+1]) begin
            rem_in = diff[RANK_W:0];
            quo_in = {quo_ff[RANK_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[RANK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(RANK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hdl/rtat_tables.sv
// Address table and rank map memories with registered read data.
`default_nettype none

module rtat_tables
   import rtat_pkg::*;
#(
   parameter int NUM_BANKS  = NUM_BANKS_DEF,
   parameter int ADDR_DEPTH = ADDR_DEPTH_DEF,
   parameter int RANK_DEPTH = RANK_DEPTH_DEF,
   localparam int AT_DEPTH  = NUM_BANKS * ADDR_DEPTH,
   localparam int AT_AW     = $clog2(AT_DEPTH),
   localparam int RM_AW     = $clog2(RANK_DEPTH)
)
(
   input  wire logic               clock,
   input  wire tbl_ctl_type        ctl,
   input  wire logic [AT_AW-1:0]   at_waddr,
   input  wire logic [ENTRY_W-1:0] at_wdata,
   input  wire logic [AT_AW-1:0]   at_raddr,
   output logic [ENTRY_W-1:0]      at_rdata,
   input  wire logic [RM_AW-1:0]   rm_waddr,
   input  wire logic [MAP_W-1:0]   rm_wdata,
   input  wire logic [RM_AW-1:0]   rm_raddr,
   output logic [MAP_W-1:0]        rm_rdata
);

   logic [ENTRY_W-1:0] at_mem [AT_DEPTH];
   logic [MAP_W-1:0]   rm_mem [RANK_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.at_we) begin
         at_mem[at_waddr] <= at_wdata;
      end
      if (ctl.at_re) begin
         at_rdata <= at_mem[at_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rm_we) begin
         rm_mem[rm_waddr] <= rm_wdata;
      end
      if (ctl.rm_re) begin
         rm_rdata <= rm_mem[rm_raddr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/rank_to_address_translate_top.sv
// Top level of the rank-to-address translator: sequencer, datapath and ports.
`default_nettype none

// Translates a communicator rank into a 64-bit address table entry, one
// transaction at a time. A request either looks up a rank, writes one
// address table entry (bank_index, slot_index, entry_value) or writes one
// rank map entry (rank -> bank_index, slot_index); every request returns
// exactly one response. req_ready is high only while the sequencer is idle,
// and a finished response waits in the output register so the next request
// can be taken while the previous response is still pending. Writes and
// errors caught at decode go from decode straight to the output state;
// direct, offset and stride lookups pass through multiply, sum, range check
// and table read, and a slot out of range skips the read; lut lookups read
// the rank map in place of multiply and sum; block-stride lookups first wait
// for the 10-step restoring divider that forms rank / block_size. The
// sequencer is back in idle on the edge where rsp_valid rises, so the next
// request can be taken in the cycle after that edge. One multiplier,
// registered, forms the stride or block product. The tables hold no reset
// value: reading an entry that was never written returns whatever the
// memory holds. Configuration registers may be written only while no
// transaction is in flight.

module rank_to_address_translate_top
   import rtat_pkg::*;
#(
   parameter int NUM_BANKS  = NUM_BANKS_DEF,
   parameter int ADDR_DEPTH = ADDR_DEPTH_DEF,
   parameter int RANK_DEPTH = RANK_DEPTH_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [REQ_W-1:0]      req_type,
   input  wire logic [RANK_W-1:0]     req_rank,
   input  wire logic [BANK_W-1:0]     req_bank_index,
   input  wire logic [SLOT_W-1:0]     req_slot_index,
   input  wire logic [ENTRY_W-1:0]    req_entry_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ENTRY_W-1:0]         rsp_address_entry,
   output logic [SLOT_W-1:0]          rsp_computed_index,
   output logic [STATUS_W-1:0]        rsp_status,

   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int AT_AW = $clog2(NUM_BANKS * ADDR_DEPTH);
   localparam int RM_AW = $clog2(RANK_DEPTH);

   // sequencer states
   localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
   localparam logic [STATE_W-1:0] S_DEC  = 4'd1;
   localparam logic [STATE_W-1:0] S_DIV  = 4'd2;
   localparam logic [STATE_W-1:0] S_MUL  = 4'd3;
   localparam logic [STATE_W-1:0] S_SUM  = 4'd4;
   localparam logic [STATE_W-1:0] S_MAP  = 4'd5;
   localparam logic [STATE_W-1:0] S_CHK  = 4'd6;
   localparam logic [STATE_W-1:0] S_RD   = 4'd7;
   localparam logic [STATE_W-1:0] S_OUT  = 4'd8;

   // configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [BANK_W-1:0] bank_sel_ff;
   logic [RANK_W-1:0] base_off_ff;
   logic [RANK_W-1:0] stride_ff;
   logic [RANK_W-1:0] block_ff;

   // sequencer and captured request
   logic [STATE_W-1:0]         state_ff, state_in;
   logic [REQ_W-1:0]           type_ff, type_in;
   logic [RANK_W-1:0]          rank_ff, rank_in;
   logic [BANK_W-1:0]          bank_arg_ff, bank_arg_in;
   logic [SLOT_W-1:0]          slot_arg_ff, slot_arg_in;
   logic [ENTRY_W-1:0]         value_ff, value_in;

   // datapath
   logic [BANK_W-1:0]          bank_ff, bank_in;
   logic [RANK_W-1:0]          mul_a_ff, mul_a_in;
   logic signed [MULB_W-1:0]   mul_b_ff, mul_b_in;
   logic [ADDEND_W-1:0]        addend_ff, addend_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [CALC_W-1:0]          calc_ff, calc_in;

   // pending result and output register
   logic [ENTRY_W-1:0]         res_entry_ff, res_entry_in;
   logic [SLOT_W-1:0]          res_index_ff, res_index_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]         rsp_entry_ff, rsp_entry_in;
   logic [SLOT_W-1:0]          rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   // unit connections
   tbl_ctl_type                tbl_ctl;
   logic [AT_AW-1:0]           at_waddr, at_raddr;
   logic [ENTRY_W-1:0]         at_rdata;
   logic [RM_AW-1:0]           rm_waddr, rm_raddr;
   logic [MAP_W-1:0]           rm_rdata;
   logic                       div_start, div_done;
   logic [RANK_W-1:0]          div_quotient;

   logic                       accept, out_free;
   logic                       rank_bad, wr_bad, bank_bad, calc_bad;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // range checks against the table sizes
   assign rank_bad = 32'(rank_ff) >= RANK_DEPTH;
   assign wr_bad   = (32'(bank_arg_ff) >= NUM_BANKS) || (32'(slot_arg_ff) >= ADDR_DEPTH);
   assign bank_bad = 32'(bank_ff) >= NUM_BANKS;
   assign calc_bad = calc_ff[CALC_W-1] || (32'(calc_ff) >= ADDR_DEPTH);

   // flat table addresses: bank * depth + slot
   assign at_waddr = AT_AW'(32'(bank_arg_ff) * ADDR_DEPTH + 32'(slot_arg_ff));
   assign at_raddr = AT_AW'(32'(bank_ff) * ADDR_DEPTH + 32'(calc_ff));
   assign rm_waddr = RM_AW'(rank_ff);
   assign rm_raddr = RM_AW'(rank_ff);

   // configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DIRECT;
         bank_sel_ff <= '0;
         base_off_ff <= '0;
         stride_ff   <= RANK_W'(1);
         block_ff    <= RANK_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:   mode_ff     <= csr_write_data[MODE_W-1:0];
            CSR_BANK:   bank_sel_ff <= csr_write_data[BANK_W-1:0];
            CSR_OFFSET: base_off_ff <= csr_write_data[RANK_W-1:0];
            CSR_STRIDE: stride_ff   <= csr_write_data[RANK_W-1:0];
            CSR_BLOCK:  block_ff    <= csr_write_data[RANK_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: arithmetic lookup modes are reduced to slot = a * b + addend; lut modes read the slot from the rank map
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      rank_in       = rank_ff;
      bank_arg_in   = bank_arg_ff;
      slot_arg_in   = slot_arg_ff;
      value_in      = value_ff;
      bank_in       = bank_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      addend_in     = addend_ff;
      prod_in       = prod_ff;
      calc_in       = calc_ff;
      res_entry_in  = res_entry_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      tbl_ctl       = '0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // capture the transaction
            if (accept) begin
               type_in     = req_type;
               rank_in     = req_rank;
               bank_arg_in = req_bank_index;
               slot_arg_in = req_slot_index;
               value_in    = req_entry_value;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            res_entry_in  = '0;
            res_index_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_OUT;
            case (type_ff)
               REQ_LOOKUP: begin
                  bank_in   = mode_ff[0] ? '0 : bank_sel_ff;
                  mul_a_in  = rank_ff;
                  mul_b_in  = MULB_W'(1);
                  addend_in = '0;
                  state_in  = S_MUL;
                  unique case (mode_ff) inside
                     MODE_DIRECT, MODE_DIRECT_INTRA: ;
                     MODE_OFFSET, MODE_OFFSET_INTRA: begin
                        addend_in = ADDEND_W'(base_off_ff);
                     end
                     MODE_STRIDE, MODE_STRIDE_INTRA: begin
                        mul_b_in  = MULB_W'(stride_ff);
                        addend_in = ADDEND_W'(base_off_ff);
                     end
                     MODE_BLOCK, MODE_BLOCK_INTRA: begin
                        if (block_ff == '0) begin
                           res_status_in = ST_BLOCK;
                           state_in      = S_OUT;
                        end else begin
                           div_start = 1'b1;
                           mul_b_in  = MULB_W'(stride_ff) - MULB_W'(block_ff);
                           addend_in = ADDEND_W'(rank_ff) + ADDEND_W'(base_off_ff);
                           state_in  = S_DIV;
                        end
                     end
                     MODE_LUT, MODE_LUT_INTRA, MODE_MULTI_LUT: begin
                        if (rank_bad) begin
                           res_status_in = ST_RANGE;
                           state_in      = S_OUT;
                        end else begin
                           tbl_ctl.rm_re = 1'b1;
                           state_in      = S_MAP;
                        end
                     end
                     default: begin
                        res_status_in = ST_MODE;
                        state_in      = S_OUT;
                     end
                  endcase
               end
               REQ_WR_ADDR: begin
                  if (wr_bad) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     tbl_ctl.at_we = 1'b1;
                  end
               end
               REQ_WR_MAP: begin
                  if (rank_bad) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     tbl_ctl.rm_we = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            // hold until the divider hands back rank / block_size
            if (div_done) begin
               mul_a_in = div_quotient;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, mul_a_ff}) * mul_b_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            calc_in  = CALC_W'(prod_ff) + CALC_W'(addend_ff);
            state_in = S_CHK;
         end
         S_MAP: begin
            // multi lut takes its bank from the map as well
            if (mode_ff == MODE_MULTI_LUT) begin
               bank_in = rm_rdata[MAP_W-1 -: BANK_W];
            end
            calc_in  = CALC_W'(rm_rdata[SLOT_W-1:0]);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (bank_bad || calc_bad) begin
               res_status_in = ST_RANGE;
               state_in      = S_OUT;
            end else begin
               tbl_ctl.at_re = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            res_entry_in  = at_rdata;
            res_index_in  = calc_ff[SLOT_W-1:0];
            res_status_in = ST_OK;
            state_in      = S_OUT;
         end
         S_OUT: begin
            // hold here until the output register is free
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: load the pending result, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = res_entry_ff;
         rsp_index_in  = res_index_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      rank_ff       <= rank_in;
      bank_arg_ff   <= bank_arg_in;
      slot_arg_ff   <= slot_arg_in;
      value_ff      <= value_in;
      bank_ff       <= bank_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      addend_ff     <= addend_in;
      prod_ff       <= prod_in;
      calc_ff       <= calc_in;
      res_entry_ff  <= res_entry_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rtat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rank_ff),
      .divisor  (block_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rtat_tables #(
      .NUM_BANKS  (NUM_BANKS),
      .ADDR_DEPTH (ADDR_DEPTH),
      .RANK_DEPTH (RANK_DEPTH)
   ) u_tables (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .at_waddr (at_waddr),
      .at_wdata (value_ff),
      .at_raddr (at_raddr),
      .at_rdata (at_rdata),
      .rm_waddr (rm_waddr),
      .rm_wdata ({bank_arg_ff, slot_arg_ff}),
      .rm_raddr (rm_raddr),
      .rm_rdata (rm_rdata)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_address_entry  = rsp_entry_ff;
   assign rsp_computed_index = rsp_index_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

>>> hdl/rtat_checker.sv
// Port-level checks for the rank-to-address translator, bound to the top level.
`default_nettype none

module rtat_checker
   import rtat_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ENTRY_W-1:0]  rsp_address_entry,
   input wire logic [SLOT_W-1:0]   rsp_computed_index,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // one transaction in flight: ready drops right after an accept
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // any error status carries a zero entry and a zero index
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_address_entry == '0 &&
      rsp_computed_index == '0)
      else $error("error response with nonzero payload");

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address_entry) &&
      $stable(rsp_computed_index) && $stable(rsp_status))
      else $error("stalled response changed");

   // a new response never appears in the cycle right after an accept
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response issued too early");

endmodule

bind rank_to_address_translate_top rtat_checker u_rtat_checker (.*);

`default_nettype wire

>>> sim/tb_rank_to_address_translate_top.sv
// Self-checking testbench for the rank-to-address translator top level.
`timescale 1ns / 1ps

module tb_rank_to_address_translate_top;
   import rtat_pkg::*;

   localparam int NUM_BANKS  = NUM_BANKS_DEF;
   localparam int ADDR_DEPTH = ADDR_DEPTH_DEF;
   localparam int RANK_DEPTH = RANK_DEPTH_DEF;

   // request code 3 has no meaning in the block: it must answer with all zeros
   localparam logic [REQ_W-1:0]  REQ_UNUSED   = 2'd3;
   // highest mapping mode code, one of the unknown ones
   localparam logic [MODE_W-1:0] MODE_TOP     = 4'd15;
   localparam int RANDOM_PHASES  = 12;
   localparam int QUIET_PHASES   = 2;
   localparam int PHASE_REQUESTS = 75;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [RANK_W-1:0]  rank;
      logic [BANK_W-1:0]  bank;
      logic [SLOT_W-1:0]  slot;
      logic [ENTRY_W-1:0] value;
   } request_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]  entry;
      logic [SLOT_W-1:0]   index;
      logic [STATUS_W-1:0] status;
   } response_type;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [BANK_W-1:0]     bank_sel;
      logic [CSR_DATA_W-1:0] offset;
      logic [CSR_DATA_W-1:0] stride;
      logic [CSR_DATA_W-1:0] blk;
   } cfg_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   // outcome of turning a rank into a table location
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                uses_map;
      int                  bank;
      int                  slot;
   } slot_pick_type;

   // clock, reset and every block input start from known values
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_type         = '0;
   logic [RANK_W-1:0]     req_rank         = '0;
   logic [BANK_W-1:0]     req_bank_index   = '0;
   logic [SLOT_W-1:0]     req_slot_index   = '0;
   logic [ENTRY_W-1:0]    req_entry_value  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [ENTRY_W-1:0]    rsp_address_entry;
   logic [SLOT_W-1:0]     rsp_computed_index;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   // configuration as the block holds it; reset values to start with
   cfg_type active_cfg = '{MODE_DIRECT, 2'd0, 10'd0, 10'd1, 10'd1};

   // predictor copy of the tables, updated as transactions are accepted
   logic [ENTRY_W-1:0] addr_table_model [NUM_BANKS*ADDR_DEPTH];
   map_entry_type      rank_map_model   [RANK_DEPTH];

   // stimulus side bookkeeping: which entries hold data once queued writes land
   bit                 addr_written     [NUM_BANKS*ADDR_DEPTH];
   bit                 map_written      [RANK_DEPTH];
   map_entry_type      map_planned      [RANK_DEPTH];

   request_type  pending_requests[$];
   response_type expected_responses[$];
   request_type  active_request;
   int        request_count  = 0;
   int        fail_count     = 0;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   int        send_gap       = 0;
   int        recv_stall     = 0;

   rank_to_address_translate_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_rank           (req_rank),
      .req_bank_index     (req_bank_index),
      .req_slot_index     (req_slot_index),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_address_entry  (rsp_address_entry),
      .rsp_computed_index (rsp_computed_index),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Resolve a rank into (bank, slot) under a configuration. Checks follow the
   // block's order: mode, block size, rank, then bank and slot range. All
   // arithmetic is exact signed integer math, so an oversized slot is caught
   // instead of wrapping.
   function automatic slot_pick_type translate_slot(cfg_type c, logic [RANK_W-1:0] rank,
                                                    map_entry_type m);
      slot_pick_type p;
      int r;
      p = '0;
      r = int'(rank);
      if (c.mode > MODE_MULTI_LUT) begin
         p.status = ST_MODE;
         return p;
      end
      // intra modes always read bank 0
      p.bank = c.mode[0] ? 0 : int'(c.bank_sel);
      case (c.mode)
         MODE_DIRECT, MODE_DIRECT_INTRA: p.slot = r;
         MODE_OFFSET, MODE_OFFSET_INTRA: p.slot = r + int'(c.offset);
         MODE_STRIDE, MODE_STRIDE_INTRA: p.slot = r * int'(c.stride) + int'(c.offset);
         MODE_BLOCK, MODE_BLOCK_INTRA: begin
            if (c.blk == '0) begin
               p.status = ST_BLOCK;
               return p;
            end
            p.slot = (r / int'(c.blk)) * (int'(c.stride) - int'(c.blk)) + r + int'(c.offset);
         end
         MODE_LUT, MODE_LUT_INTRA: begin
            if (r >= RANK_DEPTH) begin
               p.status = ST_RANGE;
               return p;
            end
            p.uses_map = 1'b1;
            p.slot     = int'(m.slot);
         end
         default: begin
            // multi lut: the rank map supplies the bank as well
            if (r >= RANK_DEPTH) begin
               p.status = ST_RANGE;
               return p;
            end
            p.uses_map = 1'b1;
            p.bank     = int'(m.bank);
            p.slot     = int'(m.slot);
         end
      endcase
      if (p.bank >= NUM_BANKS || p.slot < 0 || p.slot >= ADDR_DEPTH) begin
         p.status = ST_RANGE;
         p.bank   = 0;
         p.slot   = 0;
      end
      return p;
   endfunction

   // Work out the response to one accepted transaction and apply its writes.
   function automatic response_type predict_response(request_type rq);
      response_type  rsp;
      slot_pick_type p;
      rsp = '0;
      case (rq.kind)
         REQ_LOOKUP: begin
            p = translate_slot(active_cfg, rq.rank, rank_map_model[rq.rank]);
            rsp.status = p.status;
            if (p.status == ST_OK) begin
               rsp.entry = addr_table_model[p.bank*ADDR_DEPTH + p.slot];
               rsp.index = p.slot[SLOT_W-1:0];
            end
         end
         REQ_WR_ADDR: begin
            if (int'(rq.bank) >= NUM_BANKS || int'(rq.slot) >= ADDR_DEPTH)
               rsp.status = ST_RANGE;
            else
               addr_table_model[int'(rq.bank)*ADDR_DEPTH + int'(rq.slot)] = rq.value;
         end
         REQ_WR_MAP: begin
            if (int'(rq.rank) >= RANK_DEPTH)
               rsp.status = ST_RANGE;
            else
               rank_map_model[rq.rank] = '{rq.bank, rq.slot};
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic request_type make_request(logic [REQ_W-1:0] kind,
                                                logic [RANK_W-1:0] rank,
                                                logic [BANK_W-1:0] bank,
                                                logic [SLOT_W-1:0] slot,
                                                logic [ENTRY_W-1:0] value);
      request_type rq;
      rq = '{kind, rank, bank, slot, value};
      return rq;
   endfunction

   function automatic cfg_type make_config(logic [MODE_W-1:0] mode, logic [BANK_W-1:0] bank,
                                           logic [CSR_DATA_W-1:0] offset,
                                           logic [CSR_DATA_W-1:0] stride,
                                           logic [CSR_DATA_W-1:0] blk);
      cfg_type c;
      c = '{mode, bank, offset, stride, blk};
      return c;
   endfunction

   // Half the time a small pool of ranks so lookups revisit entries, otherwise
   // the full range or the top end.
   function automatic logic [RANK_W-1:0] random_rank();
      case ($urandom_range(3))
         0, 1:    return RANK_W'($urandom_range(31));
         2:       return RANK_W'($urandom_range(RANK_DEPTH - 1));
         default: return RANK_W'(RANK_DEPTH - 1 - $urandom_range(15));
      endcase
   endfunction

   // Queue one transaction and track which table entries it fills.
   task automatic queue_request(input request_type rq);
      pending_requests.push_back(rq);
      if (rq.kind == REQ_WR_ADDR)
         addr_written[int'(rq.bank)*ADDR_DEPTH + int'(rq.slot)] = 1'b1;
      if (rq.kind == REQ_WR_MAP) begin
         map_written[rq.rank] = 1'b1;
         map_planned[rq.rank] = '{rq.bank, rq.slot};
      end
      if (rq.kind != REQ_UNUSED)
         request_count++;
   endtask

   // Queue a lookup of one rank, preceded by whatever writes it needs so that
   // no entry is read before it holds data.
   task automatic queue_lookup(input logic [RANK_W-1:0] rank);
      slot_pick_type p;
      p = translate_slot(active_cfg, rank, map_planned[rank]);
      if (p.uses_map && !map_written[rank]) begin
         queue_request(make_request(REQ_WR_MAP, rank, BANK_W'($urandom_range(3)),
                                    SLOT_W'($urandom_range(ADDR_DEPTH - 1)),
                                    {$urandom, $urandom}));
         p = translate_slot(active_cfg, rank, map_planned[rank]);
      end
      if (p.status == ST_OK && !addr_written[p.bank*ADDR_DEPTH + p.slot])
         queue_request(make_request(REQ_WR_ADDR, RANK_W'($urandom), BANK_W'(p.bank),
                                    SLOT_W'(p.slot), {$urandom, $urandom}));
      // fields a lookup ignores carry random junk
      queue_request(make_request(REQ_LOOKUP, rank, BANK_W'($urandom), SLOT_W'($urandom),
                                 {$urandom, $urandom}));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Write every register; only called with no transaction in flight. Unused
   // upper data bits of the narrow registers get random values.
   task automatic configure_translator(input cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_MODE, {junk[CSR_DATA_W-1:MODE_W], c.mode});
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_BANK, {junk[CSR_DATA_W-1:BANK_W], c.bank_sel});
      write_csr(CSR_OFFSET, c.offset);
      write_csr(CSR_STRIDE, c.stride);
      write_csr(CSR_BLOCK, c.blk);
      active_cfg = c;
   endtask

   // Hold the sender until the queue is empty and every response has come.
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [ENTRY_W-1:0] want,
                              input logic [ENTRY_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   // Driver: present the next pending transaction once the current one is
   // taken, with random idle bursts in between. Predict at acceptance.
   always @(posedge clock) begin
      logic launch;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else begin
         launch = !req_valid;
         if (req_valid && req_ready) begin
            expected_responses.push_back(predict_response(active_request));
            launch = 1'b1;
         end
         if (launch) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         $urandom_range(99) < send_idle_pct) begin
               // start an idle burst
               send_gap   = $urandom_range(13);
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               active_request   = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_type        <= active_request.kind;
               req_rank        <= active_request.rank;
               req_bank_index  <= active_request.bank;
               req_slot_index  <= active_request.slot;
               req_entry_value <= active_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response against the oldest prediction,
   // and stall the response channel in random bursts.
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               fail_count++;
               $error("response with none outstanding: entry 0x%0h index %0d status %0d",
                      rsp_address_entry, rsp_computed_index, rsp_status);
            end else begin
               want = expected_responses.pop_front();
               check_field("address_entry", want.entry, rsp_address_entry);
               check_field("computed_index", ENTRY_W'(want.index), ENTRY_W'(rsp_computed_index));
               check_field("status", ENTRY_W'(want.status), ENTRY_W'(rsp_status));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(99) < recv_stall_pct) begin
            recv_stall = $urandom_range(13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus: directed cases first, then random phases, each phase under a
   // fresh configuration written while the block sits idle.
   initial begin
      cfg_type c;
      int      target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 10;
      recv_stall_pct = 10;

      // reset configuration: direct mode on bank 0; fill the table corners
      queue_request(make_request(REQ_WR_ADDR, '0, 2'd0, '0, '0));
      queue_request(make_request(REQ_WR_ADDR, '1, 2'd0, '1, '1));
      queue_request(make_request(REQ_WR_ADDR, 10'h155, 2'd3, '1, 64'h8000_0000_0000_0001));
      queue_request(make_request(REQ_WR_ADDR, 10'h2AA, 2'd3, '0, 64'h0123_4567_89AB_CDEF));
      queue_lookup('0);
      queue_lookup('1);
      queue_request(make_request(REQ_WR_MAP, '1, 2'd3, '1, '1));
      queue_request(make_request(REQ_WR_MAP, '0, 2'd0, '0, '0));
      queue_request(make_request(REQ_WR_MAP, 10'd1, 2'd3, '0, 64'h5A));
      // unused request code with every field bit set
      queue_request(make_request(REQ_UNUSED, '1, '1, '1, '1));
      wait_for_drain();

      // multi lut: bank and slot both come from the rank map
      configure_translator(make_config(MODE_MULTI_LUT, 2'd0, '1, '1, '0));
      queue_lookup('1);
      queue_lookup(10'd1);
      queue_lookup('0);
      wait_for_drain();

      // unknown mode
      configure_translator(make_config(MODE_TOP, 2'd3, '1, '0, '1));
      queue_lookup('0);
      wait_for_drain();

      // zero block size in a block mode
      configure_translator(make_config(MODE_BLOCK_INTRA, 2'd3, '0, 10'd1, '0));
      queue_lookup(10'd5);
      wait_for_drain();

      // largest stride and offset: slot 1023 fits, the next rank overflows
      configure_translator(make_config(MODE_STRIDE, 2'd3, '1, '1, 10'd1));
      queue_lookup('0);
      queue_lookup(10'd1);
      wait_for_drain();

      // offset pushes the top rank out of range
      configure_translator(make_config(MODE_OFFSET, 2'd1, '1, 10'd1, 10'd1));
      queue_lookup('1);
      wait_for_drain();

      // block stride with zero stride and the largest block folds rank 1023 to 0
      configure_translator(make_config(MODE_BLOCK, 2'd3, '0, '0, '1));
      queue_lookup('1);
      wait_for_drain();

      // lut intra ignores bank_select and reads bank 0
      configure_translator(make_config(MODE_LUT_INTRA, 2'd2, '0, 10'd1, 10'd1));
      queue_lookup('1);
      wait_for_drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // some phases run without idling, the last ones never idle
         if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else begin
            send_idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(25, 5);
            recv_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(25, 5);
         end

         c.mode = ($urandom_range(7) == 0) ? MODE_W'($urandom_range(15, 11))
                                           : MODE_W'($urandom_range(10));
         c.bank_sel = BANK_W'($urandom_range(3));
         case ($urandom_range(5))
            0:       c.offset = '0;
            1:       c.offset = '1;
            2, 3:    c.offset = CSR_DATA_W'($urandom_range(63));
            default: c.offset = CSR_DATA_W'($urandom_range(1023));
         endcase
         case ($urandom_range(7))
            0:       c.stride = '0;
            1:       c.stride = '1;
            2, 3:    c.stride = CSR_DATA_W'(1);
            default: c.stride = CSR_DATA_W'($urandom_range(40, 2));
         endcase
         case ($urandom_range(7))
            0:       c.blk = '0;
            1:       c.blk = '1;
            default: c.blk = CSR_DATA_W'($urandom_range(64, 1));
         endcase
         configure_translator(c);

         target = request_count + PHASE_REQUESTS;
         while (request_count < target) begin
            case ($urandom_range(19))
               0, 1, 2:
                  queue_request(make_request(REQ_WR_ADDR, RANK_W'($urandom),
                                             BANK_W'($urandom_range(3)), random_rank(),
                                             {$urandom, $urandom}));
               3, 4:
                  queue_request(make_request(REQ_WR_MAP, random_rank(),
                                             BANK_W'($urandom_range(3)),
                                             SLOT_W'($urandom_range(ADDR_DEPTH - 1)),
                                             {$urandom, $urandom}));
               5:
                  queue_request(make_request(REQ_UNUSED, RANK_W'($urandom), BANK_W'($urandom),
                                             SLOT_W'($urandom), {$urandom, $urandom}));
               default:
                  queue_lookup(random_rank());
            endcase
         end
         wait_for_drain();
      end

      // let the pipeline settle, then give the verdict
      repeat (30) @(posedge clock);
      if (fail_count == 0 && expected_responses.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
